/* rtl/core/pwmio_pkg.sv */
// Package for the 1-Wire PIO function-command block: types, codes and helper functions.
package pwmio_pkg;

	localparam int PWM_PERIOD_STEPS = 128;
	localparam int READ_BURST       = 32;
	localparam int CNT_W            = (READ_BURST > 8) ? $clog2(READ_BURST) : 3;
	localparam int Q_DEPTH          = 2;
	localparam int Q_PTR_W          = $clog2(Q_DEPTH);

	localparam logic [7:0] FC_READ_PIO   = 8'hF0;
	localparam logic [7:0] FC_READ_BURST = 8'hF5;
	localparam logic [7:0] FC_CH_WRITE   = 8'h5A;
	localparam logic [7:0] FC_CS_WRITE   = 8'hCC;
	localparam logic [7:0] FC_RESET_ACT  = 8'hC3;

	localparam logic [7:0] PAGE_BASE = 8'h88;
	localparam logic [7:0] CH_ADDR   = 8'h89;
	localparam logic [7:0] CS_FIRST  = 8'h8B;
	localparam logic [7:0] CS_ADDR   = 8'h8D;
	localparam logic [7:0] ACK_BYTE  = 8'hAA;
	localparam logic [7:0] ALL_ONES  = 8'hFF;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
		logic [7:0] pwm_compare;
	} out_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PIO_LO,
		PH_PIO_HI,
		PH_CHW_DATA,
		PH_CHW_INV,
		PH_CS_LO,
		PH_CS_HI,
		PH_CS_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_AA,
		B_DATA,
		B_BODY,
		B_CRC_LO,
		B_CRC_HI
	} back_state_t;

	typedef enum logic [1:0] {
		JOB_BURST,
		JOB_PAGE,
		JOB_ACK,
		JOB_ECHO
	} job_kind_t;

	// One queued transmit job; everything the back end needs is snapshotted here.
	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] crc;
		logic [7:0]  data;
		logic [7:0]  csr;
		logic [3:0]  idx;
		logic [7:0]  duty;
	} job_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] steps_to_latch(input logic [7:0] s);
		logic [15:0] p;
		p = {8'h00, s} * 16'd255;
		if (s == 8'(PWM_PERIOD_STEPS)) return 8'h00;
		if (s == 8'h00) return ALL_ONES;
		return 8'(p / PWM_PERIOD_STEPS);
	endfunction

	// r*PERIOD/255 via reciprocal: for x < 65535, x/255 == (x + (x>>8) + 1) >> 8
	function automatic logic [7:0] latch_to_steps(input logic [7:0] r);
		logic [15:0] x;
		logic [16:0] t;
		x = 16'(r) * 16'(PWM_PERIOD_STEPS);
		t = {1'b0, x} + 17'(x >> 8) + 17'd1;
		if (r == 8'h00) return 8'(PWM_PERIOD_STEPS);
		if (r == ALL_ONES) return 8'h00;
		return t[15:8];
	endfunction

	function automatic logic [7:0] page_read(input logic [2:0] idx, input logic [7:0] latch,
			input logic [7:0] csr);
		logic [7:0] v;
		case (idx)
			3'd1: v = latch;
			3'd0, 3'd2, 3'd3, 3'd4: v = 8'h00;
			3'd5: v = csr;
			default: v = ALL_ONES;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/pwmio_front.sv */
// Front end: accepts received bytes, tracks the command phase and queues transmit jobs.
module pwmio_front import pwmio_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  in_t  item,
	input  logic q_full,
	output logic job_push,
	output job_t job
);

	phase_t      phase_q, phase_d;
	logic [7:0]  start_q, start_d;
	logic [7:0]  waddr_q, waddr_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  csr_q, csr_d;
	logic [7:0]  duty_q, duty_d;
	logic [15:0] crc_q, crc_d;
	logic        accept;
	logic        push_c;
	logic [7:0]  b;
	logic [15:0] crc_b;
	logic [7:0]  page;
	logic [7:0]  waddr_inc;
	logic [7:0]  duty_new;

	assign item_stall = q_full;
	assign accept     = item_valid & ~q_full;
	assign b          = item.rx_byte;
	assign crc_b      = crc_byte((phase_q == PH_IDLE) ? 16'h0000 : crc_q, b);
	assign page       = start_q - PAGE_BASE;
	assign waddr_inc  = waddr_q + 8'd1;
	assign duty_new   = (~held_q == b) ? latch_to_steps(~held_q) : duty_q;
	assign job_push   = accept & push_c;

	always_comb begin
		phase_d = phase_q;
		if (item.cmd) begin
			phase_d = PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					case (b)
						FC_READ_PIO: phase_d = PH_PIO_LO;
						FC_CH_WRITE: phase_d = PH_CHW_DATA;
						FC_CS_WRITE: phase_d = PH_CS_LO;
						default:     phase_d = PH_DONE;
					endcase
				end
				PH_PIO_LO:   phase_d = PH_PIO_HI;
				PH_CHW_DATA: phase_d = PH_CHW_INV;
				PH_CHW_INV:  phase_d = PH_CHW_DATA;
				PH_CS_LO:    phase_d = PH_CS_HI;
				PH_CS_HI: begin
					if (start_q < CS_FIRST || start_q > CS_ADDR) phase_d = PH_DONE;
					else phase_d = PH_CS_DATA;
				end
				PH_CS_DATA: begin
					if (waddr_inc > CS_ADDR) phase_d = PH_DONE;
				end
				default: phase_d = PH_DONE;
			endcase
		end
	end

	always_comb begin
		start_d  = start_q;
		waddr_d  = waddr_q;
		held_d   = held_q;
		csr_d    = csr_q;
		duty_d   = duty_q;
		crc_d    = crc_q;
		push_c   = 1'b0;
		job.kind = JOB_ACK;
		job.crc  = crc_b;
		job.data = 8'h00;
		job.csr  = csr_q;
		job.idx  = 4'd0;
		job.duty = duty_q;
		if (!item.cmd) begin
			case (phase_q)
				PH_IDLE: begin
					case (b)
						FC_READ_PIO: crc_d = crc_b;
						FC_READ_BURST: begin
							crc_d    = crc_b;
							push_c   = 1'b1;
							job.kind = JOB_BURST;
							job.data = steps_to_latch(duty_q);
						end
						FC_CH_WRITE: waddr_d = CH_ADDR;
						FC_RESET_ACT: push_c = 1'b1;
						default: ;
					endcase
				end
				PH_PIO_LO: begin
					start_d = b;
					crc_d   = crc_b;
				end
				PH_PIO_HI: begin
					crc_d    = crc_b;
					push_c   = 1'b1;
					job.kind = JOB_PAGE;
					job.data = ~steps_to_latch(duty_q);
					job.idx  = (page > 8'd7) ? 4'd8 : page[3:0];
				end
				PH_CHW_DATA: held_d = b;
				PH_CHW_INV: begin
					duty_d   = duty_new;
					waddr_d  = waddr_inc;
					push_c   = 1'b1;
					job.kind = JOB_ECHO;
					job.data = held_q;
					job.duty = duty_new;
				end
				PH_CS_LO: start_d = b;
				PH_CS_HI: begin
					if (!(start_q < CS_FIRST || start_q > CS_ADDR)) waddr_d = start_q;
				end
				PH_CS_DATA: begin
					if (waddr_q == CS_ADDR) csr_d = b;
					waddr_d = waddr_inc;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= 8'h00;
			waddr_q <= 8'h00;
			held_q  <= 8'h00;
			csr_q   <= PAGE_BASE;
			duty_q  <= 8'(PWM_PERIOD_STEPS);
			crc_q   <= 16'h0000;
		end else if (accept) begin
			phase_q <= phase_d;
			start_q <= start_d;
			waddr_q <= waddr_d;
			held_q  <= held_d;
			csr_q   <= csr_d;
			duty_q  <= duty_d;
			crc_q   <= crc_d;
		end
	end

endmodule

/* rtl/core/pwmio_queue.sv */
// Short job queue between the front end and the transmit back end.
module pwmio_queue import pwmio_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	localparam int CNT_QW = $clog2(Q_DEPTH + 1);

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [CNT_QW-1:0]  count_q;
	logic               do_push, do_pop;

	assign full    = (count_q == CNT_QW'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/core/pwmio_back.sv */
// Back end: plays out queued jobs one transmit byte per cycle unless stalled, with running CRC16.
module pwmio_back import pwmio_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  job_t head,
	output logic pop,
	output logic reply_valid,
	input  logic reply_stall,
	output out_t reply
);

	back_state_t      st_q, st_d;
	job_t             job_q;
	logic [15:0]      crc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             fire;
	logic             body_end;
	logic [7:0]       tx;

	assign reply_valid = (st_q != B_IDLE);
	assign fire        = reply_valid & ~reply_stall;
	assign pop         = (st_q == B_IDLE) & ~q_empty;
	assign body_end    = (job_q.kind == JOB_BURST) ? (cnt_q == CNT_W'(READ_BURST - 1))
	                                               : (cnt_q == CNT_W'(7));

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					case (head.kind)
						JOB_BURST: st_d = B_BODY;
						JOB_PAGE:  st_d = head.idx[3] ? B_CRC_LO : B_BODY;
						default:   st_d = B_AA;
					endcase
				end
			end
			B_AA:     if (fire) st_d = (job_q.kind == JOB_ECHO) ? B_DATA : B_IDLE;
			B_DATA:   if (fire) st_d = B_IDLE;
			B_BODY:   if (fire && body_end) st_d = B_CRC_LO;
			B_CRC_LO: if (fire) st_d = B_CRC_HI;
			B_CRC_HI: if (fire) st_d = B_IDLE;
			default:  st_d = B_IDLE;
		endcase
	end

	always_comb begin
		case (st_q)
			B_AA:     tx = ACK_BYTE;
			B_DATA:   tx = job_q.data;
			B_BODY:   tx = (job_q.kind == JOB_BURST) ? job_q.data
			                : page_read(cnt_q[2:0], job_q.data, job_q.csr);
			B_CRC_LO: tx = ~crc_q[7:0];
			B_CRC_HI: tx = ~crc_q[15:8];
			default:  tx = 8'h00;
		endcase
		reply.tx_byte     = tx;
		reply.last        = (st_q == B_CRC_HI) || (st_q == B_DATA)
		                    || (st_q == B_AA && job_q.kind == JOB_ACK);
		reply.pwm_compare = job_q.duty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (pop) cnt_q <= (head.kind == JOB_PAGE) ? CNT_W'(head.idx[2:0]) : '0;
			else if (fire && st_q == B_BODY) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
			crc_q <= head.crc;
		end else if (fire && st_q == B_BODY) begin
			crc_q <= crc_byte(crc_q, tx);
		end
	end

endmodule

/* rtl/core/onewire_pwm_io_function_commands_top.sv */
// Top level of the 1-Wire PIO function-command block with PWM output latch.
// Each received byte or bus reset is taken by the front end, which keeps the
// command phase, addresses, control/status register and PWM duty, and queues a transmit job
// in a two-entry queue; input stalls only while that queue is full. The back end pops a job
// from the queue head while idle, starts it in the next cycle and then sends one byte per
// cycle while the receiver does not stall, returning to idle after each job's final byte.
// A job sends 34 bytes for F5, up to 10 for a page read, 2 for a channel write echo, 1 for
// C3. The CRC16 is folded in once for each body byte sent.
module onewire_pwm_io_function_commands_top import pwmio_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  in_t  cmd_item,
	output logic reply_valid,
	input  logic reply_stall,
	output out_t reply_item
);

	logic q_push, q_full, q_pop, q_empty;
	job_t q_in, q_head;

	pwmio_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (cmd_valid),
		.item_stall (cmd_stall),
		.item       (cmd_item),
		.q_full     (q_full),
		.job_push   (q_push),
		.job        (q_in)
	);

	pwmio_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	pwmio_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head        (q_head),
		.pop         (q_pop),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply       (reply_item)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("job pushed into full queue");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(reply_valid && !reply_stall && reply_item.last) |=> !reply_valid)
		else $error("back end did not return to idle after final byte");

	a_compare_range: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid |-> (reply_item.pwm_compare <= 8'(PWM_PERIOD_STEPS)))
		else $error("pwm compare beyond period");

endmodule
